// ===== hdl/wsenc_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket client frame encoder package
// Shared types, constants and helper functions for the encoder modules.
// ----------------------------------------------------------------------------
package wsenc_pkg;

   localparam int CAPACITY_WIDTH   = 32;
   localparam int LENGTH_WIDTH     = 63;
   localparam int BYTE_WIDTH       = 8;
   localparam int NIBBLE_WIDTH     = 4;
   localparam int STATUS_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int BYTE_INDEX_WIDTH = 4;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [CAPACITY_WIDTH-1:0] CAPACITY_RESET = 32'd125;
   localparam logic [BYTE_WIDTH-1:0]     MASK_RESET     = 8'h2A;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_CAPACITY = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MASK_BYTE      = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_FRAME = 2'd2;

   localparam logic [LENGTH_WIDTH-1:0] SHORT_LENGTH_LIMIT  = 63'd126;
   localparam logic [LENGTH_WIDTH-1:0] MEDIUM_LENGTH_LIMIT = 63'd65536;
   localparam logic [BYTE_WIDTH-1:0]   LEN_CODE_MEDIUM     = 8'd126;
   localparam logic [BYTE_WIDTH-1:0]   LEN_CODE_LONG       = 8'd127;
   localparam logic [BYTE_WIDTH-1:0]   MASK_BIT            = 8'h01 << 7;

   localparam logic [BYTE_INDEX_WIDTH-1:0] BASE_HEADER_BYTES = 4'd2;
   localparam logic [BYTE_INDEX_WIDTH-1:0] MASK_KEY_BYTES    = 4'd4;
   localparam logic [BYTE_INDEX_WIDTH-1:0] EXT_BYTES_MEDIUM  = 4'd2;
   localparam logic [BYTE_INDEX_WIDTH-1:0] EXT_BYTES_LONG    = 4'd8;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_MEDIUM,
      LEN_LONG
   } len_class_type;

   typedef struct packed {
      kind_type                  kind;
      len_class_type             len_class;
      logic [BYTE_WIDTH-1:0]     header_byte;
      logic [LENGTH_WIDTH-1:0]   payload_length;
      logic [BYTE_WIDTH-1:0]     data_byte;
      logic                      last;
      logic [STATUS_WIDTH-1:0]   status;
   } job_type;

   function automatic logic [BYTE_INDEX_WIDTH-1:0] ext_bytes(input len_class_type len_class);
      logic [BYTE_INDEX_WIDTH-1:0] result;
      case (len_class)
         LEN_MEDIUM: result = EXT_BYTES_MEDIUM;
         LEN_LONG:   result = EXT_BYTES_LONG;
         default:    result = '0;
      endcase
      return result;
   endfunction

   function automatic logic [BYTE_INDEX_WIDTH-1:0] header_bytes(input len_class_type len_class);
      return BASE_HEADER_BYTES + ext_bytes(len_class) + MASK_KEY_BYTES;
   endfunction

endpackage

// ===== hdl/wsenc_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket encoder front end
// Accepts commands, tracks the open frame, checks the frame size against
// the capacity and hands one classified job per command to the queue.
// ----------------------------------------------------------------------------
module wsenc_front
   import wsenc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [NIBBLE_WIDTH-1:0]   req_frame_flags,
   input  logic [NIBBLE_WIDTH-1:0]   req_frame_opcode,
   input  logic [LENGTH_WIDTH-1:0]   req_payload_length,
   input  logic [BYTE_WIDTH-1:0]     req_data_byte,
   input  logic [CAPACITY_WIDTH-1:0] frame_capacity,
   input  logic                      queue_full,
   output logic                      push,
   output job_type                   push_job
);

   logic                    frame_open_ff;
   logic                    frame_open_in;
   logic [LENGTH_WIDTH-1:0] remaining_ff;
   logic [LENGTH_WIDTH-1:0] remaining_in;

   logic                      accept;
   len_class_type             len_class;
   logic [CAPACITY_WIDTH:0]   low_total;
   logic                      oversize;
   logic                      final_byte;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   always_comb begin
      if (req_payload_length < SHORT_LENGTH_LIMIT) begin
         len_class = LEN_SHORT;
      end else if (req_payload_length < MEDIUM_LENGTH_LIMIT) begin
         len_class = LEN_MEDIUM;
      end else begin
         len_class = LEN_LONG;
      end
   end

   assign low_total = {1'b0, req_payload_length[CAPACITY_WIDTH-1:0]}
                    + (CAPACITY_WIDTH+1)'(header_bytes(len_class));
   assign oversize  = (req_payload_length[LENGTH_WIDTH-1:CAPACITY_WIDTH] != '0)
                   || (low_total > {1'b0, frame_capacity});
   assign final_byte = (remaining_ff == LENGTH_WIDTH'(1));

   always_comb begin
      frame_open_in          = frame_open_ff;
      remaining_in           = remaining_ff;
      push_job.kind          = KIND_ERROR;
      push_job.len_class     = len_class;
      push_job.header_byte   = {req_frame_flags, req_frame_opcode};
      push_job.payload_length = req_payload_length;
      push_job.data_byte     = req_data_byte;
      push_job.last          = 1'b1;
      push_job.status        = STATUS_OK;
      if (req_cmd) begin
         if (!frame_open_ff) begin
            push_job.status = STATUS_NO_FRAME;
         end else begin
            push_job.kind = KIND_DATA;
            push_job.last = final_byte;
            if (accept) begin
               remaining_in  = remaining_ff - LENGTH_WIDTH'(1);
               frame_open_in = !final_byte;
            end
         end
      end else if (oversize) begin
         push_job.status = STATUS_OVERSIZE;
         if (accept) begin
            remaining_in  = '0;
            frame_open_in = 1'b0;
         end
      end else begin
         push_job.kind = KIND_HEADER;
         push_job.last = (req_payload_length == '0);
         if (accept) begin
            remaining_in  = req_payload_length;
            frame_open_in = (req_payload_length != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

// ===== hdl/wsenc_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket encoder job queue
// Short register FIFO that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module wsenc_queue
   import wsenc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   job_type                  entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff;
   logic [PTR_WIDTH-1:0]     wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff;
   logic [PTR_WIDTH-1:0]     rd_ptr_in;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [COUNT_WIDTH-1:0]   count_in;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : ptr + PTR_WIDTH'(1);
   endfunction

   assign full      = (count_ff == COUNT_WIDTH'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/wsenc_back.sv =====
// ----------------------------------------------------------------------------
// WebSocket encoder byte sequencer
// Expands each queued job into output beats: header bytes, extended length,
// masking key, masked payload or error status, through an output register.
// ----------------------------------------------------------------------------
module wsenc_back
   import wsenc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  job_type                 job,
   output logic                    pop,
   input  logic [BYTE_WIDTH-1:0]   mask_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BYTE_WIDTH-1:0]   rsp_out_byte,
   output logic                    rsp_frame_last,
   output logic [STATUS_WIDTH-1:0] rsp_status
);

   logic [BYTE_INDEX_WIDTH-1:0] index_ff;
   logic [BYTE_INDEX_WIDTH-1:0] index_in;
   logic                        valid_ff;
   logic                        valid_in;
   logic [BYTE_WIDTH-1:0]       out_byte_ff;
   logic [BYTE_WIDTH-1:0]       out_byte_in;
   logic                        last_ff;
   logic                        last_in;
   logic [STATUS_WIDTH-1:0]     status_ff;
   logic [STATUS_WIDTH-1:0]     status_in;

   logic                        load;
   logic [BYTE_INDEX_WIDTH-1:0] ext_count;
   logic [BYTE_INDEX_WIDTH-1:0] final_index;
   logic [BYTE_INDEX_WIDTH-1:0] length_select;
   logic [63:0]                 length_word;
   logic [BYTE_WIDTH-1:0]       length_code;
   logic [BYTE_WIDTH-1:0]       header_out;
   logic                        job_done;

   assign load          = job_valid && (!valid_ff || rsp_ready);
   assign ext_count     = ext_bytes(job.len_class);
   assign final_index   = header_bytes(job.len_class) - BYTE_INDEX_WIDTH'(1);
   assign length_select = ext_count + BYTE_INDEX_WIDTH'(1) - index_ff;
   assign length_word   = {1'b0, job.payload_length};
   assign job_done      = (job.kind != KIND_HEADER) || (index_ff == final_index);
   assign pop           = load && job_done;

   always_comb begin
      case (job.len_class)
         LEN_MEDIUM: length_code = LEN_CODE_MEDIUM;
         LEN_LONG:   length_code = LEN_CODE_LONG;
         default:    length_code = {1'b0, job.payload_length[6:0]};
      endcase
   end

   always_comb begin
      if (index_ff == '0) begin
         header_out = job.header_byte;
      end else if (index_ff == BYTE_INDEX_WIDTH'(1)) begin
         header_out = MASK_BIT | length_code;
      end else if (index_ff < BASE_HEADER_BYTES + ext_count) begin
         header_out = length_word[{length_select[2:0], 3'b000} +: BYTE_WIDTH];
      end else begin
         header_out = mask_byte;
      end
   end

   always_comb begin
      index_in    = index_ff;
      valid_in    = valid_ff && !rsp_ready;
      out_byte_in = out_byte_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      if (load) begin
         valid_in  = 1'b1;
         status_in = job.status;
         index_in  = job_done ? '0 : index_ff + BYTE_INDEX_WIDTH'(1);
         case (job.kind)
            KIND_HEADER: begin
               out_byte_in = header_out;
               last_in     = job.last && (index_ff == final_index);
            end
            KIND_DATA: begin
               out_byte_in = job.data_byte ^ mask_byte;
               last_in     = job.last;
            end
            default: begin
               out_byte_in = '0;
               last_in     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_frame_last = last_ff;
   assign rsp_status     = status_ff;

endmodule

// ===== hdl/websocket_client_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// WebSocket client frame encoder
// Builds masked client WebSocket frames as a byte stream, one byte per beat.
// ----------------------------------------------------------------------------
// A payload-byte command produces one output beat and the block takes one
// command per cycle while the queue has room, so payload streams at one byte
// per cycle. A start command produces 6, 8 or 14 header beats (short, 16-bit or
// 64-bit length), which the byte sequencer emits at one beat per cycle unless
// stalled; a job queue of QUEUE_DEPTH entries lets new commands be taken while
// a header is still going out. Oversized frames and payload bytes with no open
// frame give one beat with out_byte zero, frame_last set and a nonzero status.
module websocket_client_frame_encoder
   import wsenc_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [NIBBLE_WIDTH-1:0]    req_frame_flags,
   input  logic [NIBBLE_WIDTH-1:0]    req_frame_opcode,
   input  logic [LENGTH_WIDTH-1:0]    req_payload_length,
   input  logic [BYTE_WIDTH-1:0]      req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BYTE_WIDTH-1:0]      rsp_out_byte,
   output logic                       rsp_frame_last,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [CAPACITY_WIDTH-1:0] capacity_ff;
   logic [CAPACITY_WIDTH-1:0] capacity_in;
   logic [BYTE_WIDTH-1:0]     mask_ff;
   logic [BYTE_WIDTH-1:0]     mask_in;

   logic    queue_full;
   logic    queue_push;
   job_type queue_push_job;
   logic    queue_pop;
   logic    queue_not_empty;
   job_type queue_head_job;

   always_comb begin
      capacity_in = capacity_ff;
      mask_in     = mask_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_CAPACITY: capacity_in = csr_write_data[CAPACITY_WIDTH-1:0];
            CSR_MASK_BYTE:      mask_in     = csr_write_data[BYTE_WIDTH-1:0];
            default:            capacity_in = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         mask_ff     <= MASK_RESET;
      end else begin
         capacity_ff <= capacity_in;
         mask_ff     <= mask_in;
      end
   end

   wsenc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_frame_flags    (req_frame_flags),
      .req_frame_opcode   (req_frame_opcode),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .frame_capacity     (capacity_ff),
      .queue_full         (queue_full),
      .push               (queue_push),
      .push_job           (queue_push_job)
   );

   wsenc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_job  (queue_push_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_job  (queue_head_job)
   );

   wsenc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_not_empty),
      .job            (queue_head_job),
      .pop            (queue_pop),
      .mask_byte      (mask_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_status     (rsp_status)
   );

endmodule
